[design/assert_macros.svh]
// Assertion helpers shared by the scanner modules.
// Each expects signals named clock and reset in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[design/stt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

   // Offset counter width.
   localparam int POS_BITS = 16;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam int WIDE_W = POS_BITS + 17;

   localparam int FIELD_W = 16;
   localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};
   localparam int KIND_W = 5;

   // Up to three tokens per byte; four-entry queue.
   localparam int MAX_RES = 3;
   localparam int CNT_W = $clog2(MAX_RES + 1);
   localparam int Q_DEPTH = 4;
   localparam int QPTR_W = $clog2(Q_DEPTH);
   localparam int QCNT_W = $clog2(Q_DEPTH + 1);

   // Token kinds
   localparam logic [KIND_W-1:0] K_PLUS    = 5'd0;
   localparam logic [KIND_W-1:0] K_MINUS   = 5'd1;
   localparam logic [KIND_W-1:0] K_STAR    = 5'd2;
   localparam logic [KIND_W-1:0] K_LPAREN  = 5'd3;
   localparam logic [KIND_W-1:0] K_RPAREN  = 5'd4;
   localparam logic [KIND_W-1:0] K_LBRACE  = 5'd5;
   localparam logic [KIND_W-1:0] K_RBRACE  = 5'd6;
   localparam logic [KIND_W-1:0] K_LBRACK  = 5'd7;
   localparam logic [KIND_W-1:0] K_RBRACK  = 5'd8;
   localparam logic [KIND_W-1:0] K_DOT     = 5'd9;
   localparam logic [KIND_W-1:0] K_COMMA   = 5'd10;
   localparam logic [KIND_W-1:0] K_CARET   = 5'd11;
   localparam logic [KIND_W-1:0] K_SLASH   = 5'd12;
   localparam logic [KIND_W-1:0] K_SEMI    = 5'd13;
   localparam logic [KIND_W-1:0] K_QUEST   = 5'd14;
   localparam logic [KIND_W-1:0] K_PERCENT = 5'd15;
   localparam logic [KIND_W-1:0] K_EQ      = 5'd16;
   localparam logic [KIND_W-1:0] K_NE      = 5'd17;
   localparam logic [KIND_W-1:0] K_NOT     = 5'd18;
   localparam logic [KIND_W-1:0] K_LE      = 5'd19;
   localparam logic [KIND_W-1:0] K_LT      = 5'd20;
   localparam logic [KIND_W-1:0] K_GE      = 5'd21;
   localparam logic [KIND_W-1:0] K_GT      = 5'd22;
   localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd23;
   localparam logic [KIND_W-1:0] K_FLOAT   = 5'd24;
   localparam logic [KIND_W-1:0] K_INT     = 5'd25;
   localparam logic [KIND_W-1:0] K_STRING  = 5'd26;
   localparam logic [KIND_W-1:0] K_IDENT   = 5'd27;

   localparam logic ERR_NONE       = 1'b0;
   localparam logic ERR_UNTERM_STR = 1'b1;

   // Characters
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_UC_A    = 8'h41;
   localparam logic [7:0] CH_UC_Z    = 8'h5A;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_LC_A    = 8'h61;
   localparam logic [7:0] CH_LC_Z    = 8'h7A;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_TILDE   = 8'h7E;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_INT,
      MODE_INT_DOT,
      MODE_FLOAT,
      MODE_STRING,
      MODE_COMMENT,
      MODE_OP
   } scan_mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] len;
      logic [FIELD_W-1:0] line;
      logic               err;
   } rec_type;

   // All tokens caused by one byte.
   typedef struct packed {
      rec_type [MAX_RES-1:0] recs;
      logic [CNT_W-1:0]      cnt;
   } entry_type;

   typedef struct packed {
      logic               hit;
      logic [KIND_W-1:0]  kind;
   } kind_hit_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_digit(c) || is_alpha(c) || (c == CH_UNDER);
   endfunction

   function automatic kind_hit_type single_kind(input logic [7:0] c);
      kind_hit_type r;
      r.hit = 1'b1;
      case (c)
         CH_PLUS:    r.kind = K_PLUS;
         CH_MINUS:   r.kind = K_MINUS;
         CH_STAR:    r.kind = K_STAR;
         CH_LPAREN:  r.kind = K_LPAREN;
         CH_RPAREN:  r.kind = K_RPAREN;
         CH_LBRACE:  r.kind = K_LBRACE;
         CH_RBRACE:  r.kind = K_RBRACE;
         CH_LBRACK:  r.kind = K_LBRACK;
         CH_RBRACK:  r.kind = K_RBRACK;
         CH_DOT:     r.kind = K_DOT;
         CH_COMMA:   r.kind = K_COMMA;
         CH_CARET:   r.kind = K_CARET;
         CH_SLASH:   r.kind = K_SLASH;
         CH_SEMI:    r.kind = K_SEMI;
         CH_QUEST:   r.kind = K_QUEST;
         CH_PERCENT: r.kind = K_PERCENT;
         default: begin
            r.hit  = 1'b0;
            r.kind = K_PLUS;
         end
      endcase
      return r;
   endfunction

   // Held operator with no '=' after it.
   function automatic kind_hit_type lone_kind(input logic [7:0] c);
      kind_hit_type r;
      r.hit = 1'b1;
      case (c)
         CH_TILDE: r.kind = K_NOT;
         CH_LT:    r.kind = K_LT;
         CH_GT:    r.kind = K_GT;
         default: begin
            r.hit  = 1'b0;
            r.kind = K_NOT;
         end
      endcase
      return r;
   endfunction

   function automatic logic [KIND_W-1:0] paired_kind(input logic [7:0] c);
      logic [KIND_W-1:0] k;
      case (c)
         CH_EQ:    k = K_EQ;
         CH_TILDE: k = K_NE;
         CH_LT:    k = K_LE;
         CH_GT:    k = K_GE;
         default:  k = K_ASSIGN;
      endcase
      return k;
   endfunction

   function automatic logic [FIELD_W-1:0] clamp16(input logic [POS_BITS:0] v);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(v);
      return (w > WIDE_W'(FIELD_MAX)) ? FIELD_MAX : w[FIELD_W-1:0];
   endfunction

   function automatic rec_type make_rec(input logic [KIND_W-1:0] kind,
                                        input logic [POS_BITS-1:0] start,
                                        input logic [POS_BITS:0] stop,
                                        input logic err,
                                        input logic [FIELD_W-1:0] line);
      rec_type r;
      logic [POS_BITS:0] start_x;
      logic [POS_BITS:0] span;
      start_x = {1'b0, start};
      span    = (stop > start_x) ? (stop - start_x) : '0;
      r.kind  = kind;
      r.start = clamp16(start_x);
      r.len   = clamp16(span);
      r.line  = line;
      r.err   = err;
      return r;
   endfunction

endpackage

`default_nettype wire

[design/source_text_tokenizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexical scanner: one source byte per item in, token records out
// (kind, start offset, length, line, error flag, last-of-item flag). The
// front end classifies each byte and can take a new byte every cycle; a byte
// that ends a token writes all the tokens it causes (up to three, e.g.
// integer, dot and identifier at end of text) as one entry into a four-entry
// queue. The back end drains it one token per cycle, while rsp_ready allows,
// into a registered output, so the sustained rate is one byte per cycle as
// long as bytes average at most one token each; a byte with more tokens holds
// the queue head until all are out, and the front stalls only when the queue
// is full. Each token is held in a queue slot and then in the output register.
// A zero byte, or req_final_req on a byte, ends the text: pending tokens are
// flushed, and offsets and line numbers restart for the next text. An open
// string at end of text comes out as a string token with the error flag set.
// Offsets, lengths and line numbers saturate at 65535.

module source_text_tokenizer (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_ch,
   input  wire logic         req_final_req,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [4:0]        rsp_token_kind,
   output logic [15:0]       rsp_start_offset,
   output logic [15:0]       rsp_token_length,
   output logic [15:0]       rsp_line_number,
   output logic              rsp_error_code,
   output logic              rsp_run_last
);
   import stt_pkg::*;

   // Front end to queue
   logic       q_push, q_full;
   entry_type  q_entry;

   // Queue to back end
   logic       q_pop, q_head_valid;
   entry_type  q_head;

   stt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_final_req (req_final_req),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   stt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   stt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_head_valid),
      .head             (q_head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_line_number  (rsp_line_number),
      .rsp_error_code   (rsp_error_code),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

`default_nettype wire

[design/stt_front.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module stt_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_ch,
   input  wire logic                req_final_req,
   input  wire logic                q_full,
   output logic                     q_push,
   output stt_pkg::entry_type       q_entry
);
   import stt_pkg::*;

   scan_mode_type        mode_ff, mode_in, mid_mode;
   logic [7:0]           quote_ff, quote_in, mid_quote;
   logic [7:0]           pending_ff, pending_in, mid_pending;
   logic [POS_BITS-1:0]  tstart_ff, tstart_in, mid_tstart;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [FIELD_W-1:0]   line_ff, line_in, mid_line;
   logic                 do_start, do_flush, accept;
   logic [POS_BITS:0]    cur_x, stop_x;
   logic [POS_BITS-1:0]  dot_at;
   logic [CNT_W-1:0]     n;
   entry_type            ent;
   kind_hit_type         sk, lk, fk;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign cur_x     = {1'b0, pos_ff};
   assign do_flush  = (req_ch == CH_NUL) || req_final_req;
   assign stop_x    = (req_ch == CH_NUL) ? cur_x : cur_x + 1'b1;
   assign sk        = single_kind(req_ch);
   assign lk        = lone_kind(pending_ff);
   assign fk        = lone_kind(mid_pending);

   // Next state: scan the byte, then apply end-of-text flush.
   always_comb begin
      do_start    = 1'b0;
      mid_mode    = mode_ff;
      mid_quote   = quote_ff;
      mid_pending = pending_ff;
      mid_tstart  = tstart_ff;
      mid_line    = line_ff;
      if (req_ch != CH_NUL) begin
         case (mode_ff)
            MODE_IDENT:   do_start = !is_word(req_ch);
            MODE_INT: begin
               if (req_ch == CH_DOT) mid_mode = MODE_INT_DOT;
               else                  do_start = !is_digit(req_ch);
            end
            MODE_INT_DOT: begin
               if (is_digit(req_ch)) mid_mode = MODE_FLOAT;
               else                  do_start = 1'b1;
            end
            MODE_FLOAT:   do_start = !is_digit(req_ch);
            MODE_STRING: begin
               if (req_ch == quote_ff) mid_mode = MODE_IDLE;
            end
            MODE_COMMENT: do_start = (req_ch == CH_NL);
            MODE_OP: begin
               if (req_ch == CH_EQ) mid_mode = MODE_IDLE;
               else                 do_start = 1'b1;
            end
            default:      do_start = 1'b1;
         endcase
         if (do_start) begin
            mid_mode = MODE_IDLE;
            if (req_ch == CH_NL) begin
               if (line_ff != FIELD_MAX) mid_line = line_ff + 1'b1;
            end else if (req_ch == CH_HASH) begin
               mid_mode = MODE_COMMENT;
            end else if (sk.hit) begin
               mid_mode = MODE_IDLE;
            end else if (req_ch inside {CH_EQ, CH_TILDE, CH_LT, CH_GT, CH_COLON}) begin
               mid_mode    = MODE_OP;
               mid_pending = req_ch;
               mid_tstart  = pos_ff;
            end else if (is_digit(req_ch)) begin
               mid_mode   = MODE_INT;
               mid_tstart = pos_ff;
            end else if (req_ch == CH_SQUOTE || req_ch == CH_DQUOTE) begin
               mid_mode   = MODE_STRING;
               mid_quote  = req_ch;
               mid_tstart = pos_ff;
            end else if (is_alpha(req_ch) || req_ch == CH_UNDER) begin
               mid_mode   = MODE_IDENT;
               mid_tstart = pos_ff;
            end
         end
      end
      if (do_flush) begin
         mode_in    = MODE_IDLE;
         quote_in   = '0;
         pending_in = '0;
         tstart_in  = '0;
         pos_in     = '0;
         line_in    = FIELD_W'(1);
      end else begin
         mode_in    = mid_mode;
         quote_in   = mid_quote;
         pending_in = mid_pending;
         tstart_in  = mid_tstart;
         pos_in     = (pos_ff != POS_MAX) ? pos_ff + 1'b1 : pos_ff;
         line_in    = mid_line;
      end
   end

   // Outputs: tokens caused by this byte, in order.
   always_comb begin
      ent    = '0;
      n      = '0;
      dot_at = '0;
      if (req_ch != CH_NUL) begin
         case (mode_ff)
            MODE_IDENT: begin
               if (!is_word(req_ch)) begin
                  ent.recs[n] = make_rec(K_IDENT, tstart_ff, cur_x, ERR_NONE, line_ff);
                  n = n + 1'b1;
               end
            end
            MODE_INT: begin
               if (req_ch != CH_DOT && !is_digit(req_ch)) begin
                  ent.recs[n] = make_rec(K_INT, tstart_ff, cur_x, ERR_NONE, line_ff);
                  n = n + 1'b1;
               end
            end
            MODE_INT_DOT: begin
               if (!is_digit(req_ch)) begin
                  dot_at = (cur_x > {1'b0, tstart_ff}) ? pos_ff - 1'b1 : tstart_ff;
                  ent.recs[n] = make_rec(K_INT, tstart_ff, {1'b0, dot_at}, ERR_NONE,
                                         line_ff);
                  n = n + 1'b1;
                  ent.recs[n] = make_rec(K_DOT, dot_at, {1'b0, dot_at} + 1'b1, ERR_NONE,
                                         line_ff);
                  n = n + 1'b1;
               end
            end
            MODE_FLOAT: begin
               if (!is_digit(req_ch)) begin
                  ent.recs[n] = make_rec(K_FLOAT, tstart_ff, cur_x, ERR_NONE, line_ff);
                  n = n + 1'b1;
               end
            end
            MODE_STRING: begin
               if (req_ch == quote_ff) begin
                  ent.recs[n] = make_rec(K_STRING, tstart_ff, cur_x + 1'b1, ERR_NONE,
                                         line_ff);
                  n = n + 1'b1;
               end
            end
            MODE_OP: begin
               if (req_ch == CH_EQ) begin
                  ent.recs[n] = make_rec(paired_kind(pending_ff), tstart_ff, cur_x + 1'b1,
                                         ERR_NONE, line_ff);
                  n = n + 1'b1;
               end else if (lk.hit) begin
                  ent.recs[n] = make_rec(lk.kind, tstart_ff, {1'b0, tstart_ff} + 1'b1,
                                         ERR_NONE, line_ff);
                  n = n + 1'b1;
               end
            end
            default: ;
         endcase
         if (do_start && req_ch != CH_NL && req_ch != CH_HASH && sk.hit) begin
            ent.recs[n] = make_rec(sk.kind, pos_ff, cur_x + 1'b1, ERR_NONE, line_ff);
            n = n + 1'b1;
         end
      end
      if (do_flush) begin
         case (mid_mode)
            MODE_IDENT: begin
               ent.recs[n] = make_rec(K_IDENT, mid_tstart, stop_x, ERR_NONE, line_ff);
               n = n + 1'b1;
            end
            MODE_INT: begin
               ent.recs[n] = make_rec(K_INT, mid_tstart, stop_x, ERR_NONE, line_ff);
               n = n + 1'b1;
            end
            MODE_FLOAT: begin
               ent.recs[n] = make_rec(K_FLOAT, mid_tstart, stop_x, ERR_NONE, line_ff);
               n = n + 1'b1;
            end
            MODE_INT_DOT: begin
               dot_at = (stop_x > {1'b0, mid_tstart}) ? POS_BITS'(stop_x - 1'b1)
                                                      : mid_tstart;
               ent.recs[n] = make_rec(K_INT, mid_tstart, {1'b0, dot_at}, ERR_NONE, line_ff);
               n = n + 1'b1;
               ent.recs[n] = make_rec(K_DOT, dot_at, {1'b0, dot_at} + 1'b1, ERR_NONE,
                                      line_ff);
               n = n + 1'b1;
            end
            MODE_STRING: begin
               ent.recs[n] = make_rec(K_STRING, mid_tstart, stop_x, ERR_UNTERM_STR, line_ff);
               n = n + 1'b1;
            end
            MODE_OP: begin
               if (fk.hit) begin
                  ent.recs[n] = make_rec(fk.kind, mid_tstart, {1'b0, mid_tstart} + 1'b1,
                                         ERR_NONE, line_ff);
                  n = n + 1'b1;
               end
            end
            default: ;
         endcase
      end
      ent.cnt = n;
   end

   assign q_entry = ent;
   assign q_push  = accept && (ent.cnt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         quote_ff   <= '0;
         pending_ff <= '0;
         tstart_ff  <= '0;
         pos_ff     <= '0;
         line_ff    <= FIELD_W'(1);
      end else if (accept) begin
         mode_ff    <= mode_in;
         quote_ff   <= quote_in;
         pending_ff <= pending_in;
         tstart_ff  <= tstart_in;
         pos_ff     <= pos_in;
         line_ff    <= line_in;
      end
   end

   `ASSERT_NEVER(f_line_nonzero, line_ff == '0, "line counter reached zero")
   `ASSERT_CLK(f_flush_rewinds,
      accept && do_flush |=> (pos_ff == '0) && (line_ff == FIELD_W'(1)) && (mode_ff == MODE_IDLE),
      "end of text did not rewind the scanner")

endmodule

`default_nettype wire

[design/stt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module stt_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire stt_pkg::entry_type  push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output stt_pkg::entry_type       head
);
   import stt_pkg::*;

   entry_type          slot_ff [Q_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `ASSERT_NEVER(q_push_when_full, push && full, "push into a full queue")
   `ASSERT_NEVER(q_pop_when_empty, pop && !head_valid, "pop from an empty queue")

endmodule

`default_nettype wire

[design/stt_back.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module stt_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire stt_pkg::entry_type  head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [4:0]               rsp_token_kind,
   output logic [15:0]              rsp_start_offset,
   output logic [15:0]              rsp_token_length,
   output logic [15:0]              rsp_line_number,
   output logic                     rsp_error_code,
   output logic                     rsp_run_last
);
   import stt_pkg::*;

   logic [CNT_W-1:0]  sub_ff, sub_in;
   logic              valid_ff, valid_in;
   rec_type           rec_ff, cur_rec;
   logic              last_ff, is_last, load;

   assign load    = head_valid && (!valid_ff || rsp_ready);
   assign cur_rec = head.recs[sub_ff[$clog2(MAX_RES)-1:0]];
   assign is_last = (sub_ff == head.cnt - 1'b1);
   assign pop     = load && is_last;

   always_comb begin
      sub_in   = sub_ff;
      valid_in = valid_ff;
      if (load) begin
         sub_in   = is_last ? '0 : sub_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff  <= cur_rec;
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_token_kind   = rec_ff.kind;
   assign rsp_start_offset = rec_ff.start;
   assign rsp_token_length = rec_ff.len;
   assign rsp_line_number  = rec_ff.line;
   assign rsp_error_code   = rec_ff.err;
   assign rsp_run_last     = last_ff;

   `ASSERT_NEVER(b_sub_in_range, head_valid && (sub_ff >= head.cnt),
      "token index past the end of the queued item")

endmodule

`default_nettype wire

[bench/tb_source_text_tokenizer.sv]
`timescale 1ns / 1ps

// Self-checking bench for the streaming tokenizer.
// A queue of source bytes is filled up front, and a clocked driver offers
// them one item at a time. On each accepted byte a scanner model predicts
// the tokens that byte causes and appends them to a token queue. A clocked
// monitor pops that queue for every token the block hands over and compares
// each field.

module tb_source_text_tokenizer;
   import stt_pkg::*;

   localparam int RANDOM_ITEMS = 355;

   // One source byte plus pacing hints for the driver.
   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
      logic       drain;   // hold this item back until all tokens are out
      logic       calm;    // no random idling while this item is current
   } src_byte_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] len;
      logic [FIELD_W-1:0] line;
      logic               err;
      logic               last;
   } token_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid     = 1'b0;
   logic              req_ready;
   logic [7:0]        req_ch        = 8'h00;
   logic              req_final_req = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready     = 1'b0;
   logic [4:0]        rsp_token_kind;
   logic [15:0]       rsp_start_offset;
   logic [15:0]       rsp_token_length;
   logic [15:0]       rsp_line_number;
   logic              rsp_error_code;
   logic              rsp_run_last;

   src_byte_type  source_bytes[$];
   token_rec_type token_queue[$];
   token_rec_type step_tokens[$];

   int  tokens_predicted = 0;   // driver side, blocking
   int  tokens_seen      = 0;   // monitor side, nonblocking
   int  bytes_sent       = 0;
   int  mismatch_cnt     = 0;
   logic calm_zone       = 1'b0;
   logic drain_next      = 1'b0;

   // Receiver hold-off bookkeeping.
   int   stall_left = 0;
   logic stall_done = 1'b0;

   // Scanner model state.
   scan_mode_type       sc_mode;
   logic [7:0]          sc_quote;
   logic [7:0]          sc_op;
   logic [POS_BITS-1:0] sc_start;
   logic [POS_BITS-1:0] sc_pos;
   logic [FIELD_W-1:0]  sc_line;

   always #2 clock = ~clock;

   source_text_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .req_final_req    (req_final_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_line_number  (rsp_line_number),
      .rsp_error_code   (rsp_error_code),
      .rsp_run_last     (rsp_run_last)
   );

   // ------------------------------------------------------------------
   // Scanner model
   // ------------------------------------------------------------------

   function automatic logic digit_c(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic alpha_c(input logic [7:0] c);
      return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
   endfunction

   function automatic logic word_c(input logic [7:0] c);
      return digit_c(c) || alpha_c(c) || (c == CH_UNDER);
   endfunction

   function automatic logic [FIELD_W-1:0] sat16(input logic [POS_BITS:0] v);
      return (v > FIELD_MAX) ? FIELD_MAX : v[FIELD_W-1:0];
   endfunction

   // Kind of a one-byte operator, -1 when the byte is not one.
   function automatic int single_op_kind(input logic [7:0] c);
      case (c)
         CH_PLUS:    return int'(K_PLUS);
         CH_MINUS:   return int'(K_MINUS);
         CH_STAR:    return int'(K_STAR);
         CH_LPAREN:  return int'(K_LPAREN);
         CH_RPAREN:  return int'(K_RPAREN);
         CH_LBRACE:  return int'(K_LBRACE);
         CH_RBRACE:  return int'(K_RBRACE);
         CH_LBRACK:  return int'(K_LBRACK);
         CH_RBRACK:  return int'(K_RBRACK);
         CH_DOT:     return int'(K_DOT);
         CH_COMMA:   return int'(K_COMMA);
         CH_CARET:   return int'(K_CARET);
         CH_SLASH:   return int'(K_SLASH);
         CH_SEMI:    return int'(K_SEMI);
         CH_QUEST:   return int'(K_QUEST);
         CH_PERCENT: return int'(K_PERCENT);
         default:    return -1;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] paired_op_kind(input logic [7:0] c);
      case (c)
         CH_EQ:    return K_EQ;
         CH_TILDE: return K_NE;
         CH_LT:    return K_LE;
         CH_GT:    return K_GE;
         default:  return K_ASSIGN;
      endcase
   endfunction

   task automatic reset_scanner();
      sc_mode  = MODE_IDLE;
      sc_quote = 8'h00;
      sc_op    = 8'h00;
      sc_start = '0;
      sc_pos   = '0;
      sc_line  = 16'd1;
   endtask

   // Record a token for the current byte; at most MAX_RES per byte.
   task automatic emit_token(input logic [KIND_W-1:0] kind, input logic [POS_BITS-1:0] start,
                             input logic [POS_BITS:0] stop, input logic err);
      token_rec_type t;
      if (step_tokens.size() < MAX_RES) begin
         t.kind  = kind;
         t.start = sat16({1'b0, start});
         t.len   = sat16((stop > {1'b0, start}) ? stop - {1'b0, start} : '0);
         t.line  = sc_line;
         t.err   = err;
         t.last  = 1'b0;
         step_tokens.push_back(t);
      end
   endtask

   // Held '~', '<' or '>' with no '=' after it; lone '=' and ':' give nothing.
   task automatic emit_held_op();
      case (sc_op)
         CH_TILDE: emit_token(K_NOT, sc_start, {1'b0, sc_start} + 1'b1, ERR_NONE);
         CH_LT:    emit_token(K_LT, sc_start, {1'b0, sc_start} + 1'b1, ERR_NONE);
         CH_GT:    emit_token(K_GT, sc_start, {1'b0, sc_start} + 1'b1, ERR_NONE);
         default: ;
      endcase
   endtask

   // Digits then a dot that no digit followed: integer, then the dot alone.
   task automatic emit_int_dot(input logic [POS_BITS:0] stop);
      logic [POS_BITS:0] d;
      d = (stop > {1'b0, sc_start}) ? stop - 1'b1 : {1'b0, sc_start};
      emit_token(K_INT, sc_start, d, ERR_NONE);
      emit_token(K_DOT, d[POS_BITS-1:0], d + 1'b1, ERR_NONE);
   endtask

   // Byte seen with no token open.
   task automatic begin_token(input logic [7:0] c, input logic [POS_BITS-1:0] cur);
      int k;
      k = single_op_kind(c);
      sc_mode = MODE_IDLE;
      if (c == CH_NL) begin
         if (sc_line < FIELD_MAX)
            sc_line = sc_line + 1'b1;
      end else if (c == CH_HASH) begin
         sc_mode = MODE_COMMENT;
      end else if (k >= 0) begin
         emit_token(KIND_W'(k), cur, {1'b0, cur} + 1'b1, ERR_NONE);
      end else if (c == CH_EQ || c == CH_TILDE || c == CH_LT || c == CH_GT || c == CH_COLON) begin
         sc_mode  = MODE_OP;
         sc_op    = c;
         sc_start = cur;
      end else if (digit_c(c)) begin
         sc_mode  = MODE_INT;
         sc_start = cur;
      end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
         sc_mode  = MODE_STRING;
         sc_quote = c;
         sc_start = cur;
      end else if (alpha_c(c) || c == CH_UNDER) begin
         sc_mode  = MODE_IDENT;
         sc_start = cur;
      end
   endtask

   task automatic scan_in_mode(input logic [7:0] c, input logic [POS_BITS-1:0] cur);
      case (sc_mode)
         MODE_IDENT: begin
            if (!word_c(c)) begin
               emit_token(K_IDENT, sc_start, {1'b0, cur}, ERR_NONE);
               begin_token(c, cur);
            end
         end
         MODE_INT: begin
            if (c == CH_DOT) begin
               sc_mode = MODE_INT_DOT;
            end else if (!digit_c(c)) begin
               emit_token(K_INT, sc_start, {1'b0, cur}, ERR_NONE);
               begin_token(c, cur);
            end
         end
         MODE_INT_DOT: begin
            if (digit_c(c)) begin
               sc_mode = MODE_FLOAT;
            end else begin
               emit_int_dot({1'b0, cur});
               begin_token(c, cur);
            end
         end
         MODE_FLOAT: begin
            if (!digit_c(c)) begin
               emit_token(K_FLOAT, sc_start, {1'b0, cur}, ERR_NONE);
               begin_token(c, cur);
            end
         end
         MODE_STRING: begin
            // newlines inside a string do not bump the line count
            if (c == sc_quote) begin
               emit_token(K_STRING, sc_start, {1'b0, cur} + 1'b1, ERR_NONE);
               sc_mode = MODE_IDLE;
            end
         end
         MODE_COMMENT: begin
            if (c == CH_NL)
               begin_token(c, cur);
         end
         MODE_OP: begin
            if (c == CH_EQ) begin
               emit_token(paired_op_kind(sc_op), sc_start, {1'b0, cur} + 1'b1, ERR_NONE);
               sc_mode = MODE_IDLE;
            end else begin
               emit_held_op();
               begin_token(c, cur);
            end
         end
         default: begin_token(c, cur);
      endcase
   endtask

   // End of text: flush whatever is open and restart offsets and lines.
   task automatic close_text(input logic [POS_BITS:0] stop);
      case (sc_mode)
         MODE_IDENT:   emit_token(K_IDENT, sc_start, stop, ERR_NONE);
         MODE_INT:     emit_token(K_INT, sc_start, stop, ERR_NONE);
         MODE_FLOAT:   emit_token(K_FLOAT, sc_start, stop, ERR_NONE);
         MODE_INT_DOT: emit_int_dot(stop);
         MODE_STRING:  emit_token(K_STRING, sc_start, stop, ERR_UNTERM_STR);
         MODE_OP:      emit_held_op();
         default: ;
      endcase
      reset_scanner();
   endtask

   // Predict all tokens of one accepted byte and queue them in order.
   task automatic model_byte(input logic [7:0] c, input logic fin);
      logic [POS_BITS-1:0] cur;
      token_rec_type t;
      cur = sc_pos;
      step_tokens.delete();
      if (c == CH_NUL) begin
         close_text({1'b0, cur});
      end else begin
         scan_in_mode(c, cur);
         sc_pos = (cur < POS_MAX) ? cur + 1'b1 : POS_MAX;
         if (fin)
            close_text({1'b0, cur} + 1'b1);
      end
      foreach (step_tokens[i]) begin
         t = step_tokens[i];
         t.last = (i == step_tokens.size() - 1);
         token_queue.push_back(t);
         tokens_predicted++;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------

   task automatic add_byte(input logic [7:0] c, input logic fin);
      src_byte_type b;
      b.ch    = c;
      b.fin   = fin;
      b.drain = drain_next;
      // a stretch in the middle of the random part runs with no idling
      b.calm  = (source_bytes.size() >= 200) && (source_bytes.size() < 290);
      drain_next = 1'b0;
      source_bytes.push_back(b);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i], 1'b0);
   endtask

   // Flag the most recently queued byte as the end of its text.
   task automatic mark_final();
      src_byte_type b;
      b = source_bytes.pop_back();
      b.fin = 1'b1;
      source_bytes.push_back(b);
   endtask

   function automatic logic [7:0] pick(input string pool);
      return pool[$urandom_range(pool.len() - 1)];
   endfunction

   // One mostly well-formed lexeme; a few picks are noise.
   task automatic add_random_token();
      int n;
      logic [7:0] q;
      case ($urandom_range(11))
         0: add_byte(pick("+-*(){}[].,^/;?%"), 1'b0);
         1: begin
            add_byte(pick("=~<>:"), 1'b0);
            add_byte(CH_EQ, 1'b0);
         end
         2: add_byte(pick("=~<>:"), 1'b0);
         3: repeat ($urandom_range(1, 4)) add_byte(pick("0123456789"), 1'b0);
         4: begin
            repeat ($urandom_range(1, 3)) add_byte(pick("0123456789"), 1'b0);
            add_byte(CH_DOT, 1'b0);
            repeat ($urandom_range(1, 3)) add_byte(pick("0123456789"), 1'b0);
         end
         5: begin
            repeat ($urandom_range(1, 3)) add_byte(pick("0123456789"), 1'b0);
            add_byte(CH_DOT, 1'b0);
         end
         6: begin
            add_byte(pick("abczAZ_q"), 1'b0);
            repeat ($urandom_range(0, 4)) add_byte(pick("az09_ZAm"), 1'b0);
         end
         7: begin
            q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
            n = $urandom_range(0, 5);
            add_byte(q, 1'b0);
            repeat (n) add_byte(pick("ab1 +\n=#.x"), 1'b0);
            // now and then leave it open so the end of text catches it
            if ($urandom_range(5) != 0)
               add_byte(q, 1'b0);
         end
         8: begin
            add_byte(CH_HASH, 1'b0);
            repeat ($urandom_range(0, 4)) add_byte(pick("ab 1+='"), 1'b0);
            add_byte(CH_NL, 1'b0);
         end
         9:  add_byte(pick(" \t\r\n"), 1'b0);
         10: add_byte(8'($urandom_range(1, 255)), 1'b0);
         default: add_byte(CH_NL, 1'b0);
      endcase
   endtask

   // ------------------------------------------------------------------
   // Driver: offers queued bytes, predicts on each accepted item
   // ------------------------------------------------------------------

   always @(posedge clock) begin : drive_proc
      logic idle_now;
      src_byte_type nxt;
      if (reset) begin
         reset_scanner();
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            model_byte(req_ch, req_final_req);
            bytes_sent <= bytes_sent + 1;
         end
         // free to move on when nothing is offered or the offer just went in
         if (!req_valid || req_ready) begin
            idle_now = !calm_zone && ($urandom_range(99) < 15);
            if (source_bytes.size() > 0 && !idle_now &&
                (!source_bytes[0].drain || tokens_predicted == tokens_seen)) begin
               nxt = source_bytes.pop_front();
               req_ch        <= nxt.ch;
               req_final_req <= nxt.fin;
               calm_zone     <= nxt.calm;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each handed-over token, paces rsp_ready
   // ------------------------------------------------------------------

   task automatic check_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatch_cnt++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor_proc
      token_rec_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (token_queue.size() == 0) begin
               mismatch_cnt++;
               $display("%0t: unexpected token: expected none, got kind %0d start %0d",
                        $time, rsp_token_kind, rsp_start_offset);
            end else begin
               want = token_queue.pop_front();
               check_field("token_kind", 32'(want.kind), 32'(rsp_token_kind));
               check_field("start_offset", 32'(want.start), 32'(rsp_start_offset));
               check_field("token_length", 32'(want.len), 32'(rsp_token_length));
               check_field("line_number", 32'(want.line), 32'(rsp_line_number));
               check_field("error_code", 32'(want.err), 32'(rsp_error_code));
               check_field("run_last", 32'(want.last), 32'(rsp_run_last));
            end
            tokens_seen <= tokens_seen + 1;
         end
         // One long hold-off once traffic is flowing: the sender keeps
         // offering, so the token queue fills and req_ready drops.
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!stall_done && bytes_sent >= 120) begin
            rsp_ready  <= 1'b0;
            stall_left <= 80;
            stall_done <= 1'b1;
         end else begin
            rsp_ready <= calm_zone || ($urandom_range(99) >= 15);
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin : main_proc
      int n;
      int target;

      // Directed: whitespace, lone '=' and ':', the '~=' and '>=' operators,
      // a held '<' cut off by an unknown high byte.
      add_text("_9 \t\r=:~=<");
      add_byte(8'hFF, 1'b0);
      add_text(">=");
      // integer then dot then string; newline in string is not counted,
      // the one after the comment is
      add_text("3.'q\nq'#\n");
      // dot after a decimal, then a byte that yields three tokens on flush
      add_text("7.2.9.a");
      mark_final();
      // open string closed out by a zero byte, then an empty text
      add_text("\"k");
      add_byte(CH_NUL, 1'b0);
      add_byte(CH_NUL, 1'b1);

      // Random texts built from lexemes, ended by final_req or a zero byte.
      target = source_bytes.size() + RANDOM_ITEMS;
      drain_next = 1'b1;
      while (source_bytes.size() < target) begin
         if ($urandom_range(19) == 0)
            drain_next = 1'b1;
         n = $urandom_range(1, 12);
         repeat (n) begin
            add_random_token();
            if ($urandom_range(2) == 0)
               add_byte(8'h20, 1'b0);
         end
         if ($urandom_range(1))
            add_byte(CH_NUL, 1'($urandom_range(1)));
         else
            mark_final();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (source_bytes.size() != 0 || req_valid || tokens_predicted != tokens_seen)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (token_queue.size() != 0)
         $display("%0t: %0d tokens expected but never seen", $time, token_queue.size());
      if (mismatch_cnt == 0 && token_queue.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog_proc
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
